FILE: sv/fcec_pkg.sv
// shared types, constants and lookup tables for the filter cutoff / envelope depth unit
`timescale 1ns / 1ps
`default_nettype none

package fcec_pkg;

    // per-stage load strobes from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } fcec_adv_t;

    localparam logic signed [7:0]  KEY_CENTER    = 8'sd60;
    localparam int unsigned        BIAS_DIR_BIT  = 6;
    localparam logic signed [8:0]  BIAS_UP_OFS   = 9'sd33;
    localparam logic signed [8:0]  BIAS_DN_OFS   = 9'sd31;
    localparam logic signed [11:0] CUT_SCALE_OFS = 12'sd800;
    localparam logic signed [16:0] PITCH_LIMIT   = 17'sd3584;
    localparam logic signed [15:0] CUT_FLOOR     = -16'sd2048;
    localparam logic signed [16:0] CUT_ROUND     = 17'sd2056;
    localparam logic signed [9:0]  LVL_BASE      = 10'sd109;
    localparam logic [7:0]         OUT_MAX       = 8'd255;
    localparam logic [2:0]         SHIFT_KF_MAX  = 3'd4;
    localparam logic [2:0]         TS_SHIFT_BASE = 3'd5;

    // key-follow multiplier, indexes above the end read 21
    function automatic logic signed [6:0] kf_mult(input logic [4:0] idx);
        logic signed [6:0] m;
        case (idx)
            5'd0:    m = -7'sd21;
            5'd1:    m = -7'sd10;
            5'd2:    m = -7'sd5;
            5'd3:    m = 7'sd0;
            5'd4:    m = 7'sd2;
            5'd5:    m = 7'sd5;
            5'd6:    m = 7'sd8;
            5'd7:    m = 7'sd10;
            5'd8:    m = 7'sd13;
            5'd9:    m = 7'sd16;
            5'd10:   m = 7'sd18;
            5'd11:   m = 7'sd21;
            5'd12:   m = 7'sd26;
            5'd13:   m = 7'sd32;
            5'd14:   m = 7'sd42;
            default: m = 7'sd21;
        endcase
        return m;
    endfunction

    // bias multiplier, indexes above the end read the last entry
    function automatic logic signed [7:0] bias_mult(input logic [3:0] idx);
        logic signed [7:0] m;
        case (idx)
            4'd0:    m = 8'sd85;
            4'd1:    m = 8'sd42;
            4'd2:    m = 8'sd21;
            4'd3:    m = 8'sd16;
            4'd4:    m = 8'sd10;
            4'd5:    m = 8'sd5;
            4'd6:    m = 8'sd2;
            4'd7:    m = 8'sd0;
            4'd8:    m = -8'sd2;
            4'd9:    m = -8'sd5;
            4'd10:   m = -8'sd10;
            4'd11:   m = -8'sd16;
            4'd12:   m = -8'sd21;
            4'd13:   m = -8'sd74;
            default: m = -8'sd85;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: sv/fcec_pipe_ctrl.sv
// valid/ready control of the three-stage pipeline
`timescale 1ns / 1ps
`default_nettype none

module fcec_pipe_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fcec_pkg::fcec_adv_t    adv
);
    import fcec_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic rdy1, rdy2, rdy3;

    // a stage can load when empty or when its content moves on
    assign rdy3 = !v3_reg || m_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign v1_next = rdy1 ? s_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg  : v2_reg;
    assign v3_next = rdy3 ? v2_reg  : v3_reg;

    assign adv.s1 = rdy1 && s_valid;
    assign adv.s2 = rdy2 && v1_reg;
    assign adv.s3 = rdy3 && v2_reg;

    assign s_ready = rdy1;
    assign m_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted transaction did not enter stage 1");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && !m_ready))
        else $error("input stalled with a bubble in the pipeline");

    a_s2_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !rdy3) |=> (v2_reg && v3_reg))
        else $error("stage 2 transaction lost during output stall");

endmodule

`default_nettype wire

FILE: sv/fcec_cutoff_path.sv
// base filter cutoff datapath, three register stages
`timescale 1ns / 1ps
`default_nettype none

module fcec_cutoff_path (
    input  wire logic                aclk,
    input  wire fcec_pkg::fcec_adv_t adv,
    input  wire logic [6:0]          note_key,
    input  wire logic [15:0]         base_pitch,
    input  wire logic [4:0]          filter_keyfollow,
    input  wire logic [4:0]          pitch_keyfollow,
    input  wire logic [6:0]          bias_point,
    input  wire logic [3:0]          bias_level,
    input  wire logic [6:0]          cutoff_setting,
    output logic [7:0]               cutoff_out
);
    import fcec_pkg::*;

    // stage 1: key-follow product, bias factor, setting term
    logic signed [7:0]  kd;
    logic signed [6:0]  kf_f, kf_p;
    logic signed [7:0]  kf_diff;
    logic signed [15:0] kf_prod16;
    logic signed [8:0]  d_up, d_dn;
    logic signed [7:0]  fac_next;
    logic signed [11:0] cut_term_next;

    logic signed [13:0] kf_prod_reg;
    logic signed [7:0]  bias_fac_reg;
    logic signed [7:0]  bias_mul_reg;
    logic signed [11:0] cut_term_reg;
    logic [11:0]        pitch4_s1_reg;

    assign kd        = $signed({1'b0, note_key}) - KEY_CENTER;
    assign kf_f      = kf_mult(filter_keyfollow);
    assign kf_p      = kf_mult(pitch_keyfollow);
    assign kf_diff   = {kf_f[6], kf_f} - {kf_p[6], kf_p};
    assign kf_prod16 = kf_diff * kd;

    assign d_up = $signed({2'b00, bias_point}) + BIAS_UP_OFS - $signed({2'b00, note_key});
    assign d_dn = $signed({2'b00, bias_point}) - BIAS_DN_OFS - $signed({2'b00, note_key});

    always_comb begin
        fac_next = 8'sd0;
        if (!bias_point[BIAS_DIR_BIT]) begin
            // below the bias point: cut by distance
            if (d_up > 9'sd0) begin
                fac_next = 8'(-d_up);
            end
        end else begin
            // above the bias point
            if (d_dn < 9'sd0) begin
                fac_next = d_dn[7:0];
            end
        end
    end

    assign cut_term_next = $signed({1'b0, cutoff_setting, 4'b0000}) - CUT_SCALE_OFS;

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            kf_prod_reg   <= kf_prod16[13:0];
            bias_fac_reg  <= fac_next;
            bias_mul_reg  <= bias_mult(bias_level);
            cut_term_reg  <= cut_term_next;
            pitch4_s1_reg <= base_pitch[15:4];
        end
    end

    // stage 2: bias product and sum
    logic signed [15:0] c_next;
    logic signed [15:0] c_reg;
    logic [11:0]        pitch4_s2_reg;

    assign c_next = kf_prod_reg + bias_fac_reg * bias_mul_reg + cut_term_reg;

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            c_reg         <= c_next;
            pitch4_s2_reg <= pitch4_s1_reg;
        end
    end

    // stage 3: pitch limit, floor, offset, shift and cap
    logic signed [16:0] over;
    logic signed [15:0] lim;
    logic signed [16:0] biased;
    logic [12:0]        shv;
    logic [7:0]         cut_next;
    logic [7:0]         cutoff_reg;

    assign over = $signed({5'b00000, pitch4_s2_reg}) + c_reg - PITCH_LIMIT;

    always_comb begin
        if (!c_reg[15] && over > 17'sd0) begin
            lim = 16'(PITCH_LIMIT - $signed({5'b00000, pitch4_s2_reg}));
        end else if (c_reg < CUT_FLOOR) begin
            lim = CUT_FLOOR;
        end else begin
            lim = c_reg;
        end
    end

    assign biased   = lim + CUT_ROUND;
    assign shv      = biased[16:4];
    // value never goes negative here
    assign cut_next = (|shv[12:8]) ? OUT_MAX : shv[7:0];

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            cutoff_reg <= cut_next;
        end
    end

    assign cutoff_out = cutoff_reg;

endmodule

`default_nettype wire

FILE: sv/fcec_level_path.sv
// envelope level multiplier and key time subtraction datapath
`timescale 1ns / 1ps
`default_nettype none

module fcec_level_path (
    input  wire logic                aclk,
    input  wire fcec_pkg::fcec_adv_t adv,
    input  wire logic [6:0]          note_key,
    input  wire logic [6:0]          note_velocity,
    input  wire logic [6:0]          velo_sensitivity,
    input  wire logic [2:0]          depth_keyfollow,
    input  wire logic [6:0]          env_depth,
    input  wire logic [2:0]          time_keyfollow,
    output logic [7:0]               level_multiplier,
    output logic signed [6:0]        time_subtraction
);
    import fcec_pkg::*;

    // stage 1: velocity product, key shifts
    logic signed [7:0] kd;
    logic [13:0]       vprod;
    logic [2:0]        dkf_sat, tkf_sat;
    logic [2:0]        dsh, tsh;
    logic signed [7:0] ks;
    logic signed [7:0] tsv;
    logic signed [6:0] ts_next;

    logic [13:0]       vprod_reg;
    logic [6:0]        sens_reg;
    logic signed [7:0] ks_reg;
    logic [6:0]        depth_s1_reg;
    logic signed [6:0] ts_s1_reg;

    assign kd      = $signed({1'b0, note_key}) - KEY_CENTER;
    assign vprod   = note_velocity * velo_sensitivity;
    assign dkf_sat = (depth_keyfollow > SHIFT_KF_MAX) ? SHIFT_KF_MAX : depth_keyfollow;
    assign tkf_sat = (time_keyfollow > SHIFT_KF_MAX) ? SHIFT_KF_MAX : time_keyfollow;
    assign dsh     = SHIFT_KF_MAX - dkf_sat;
    assign tsh     = TS_SHIFT_BASE - tkf_sat;
    assign ks      = kd >>> dsh;
    assign tsv     = kd >>> tsh;
    assign ts_next = (tkf_sat == 3'd0) ? 7'sd0 : tsv[6:0];

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            vprod_reg    <= vprod;
            sens_reg     <= velo_sensitivity;
            ks_reg       <= ks;
            depth_s1_reg <= env_depth;
            ts_s1_reg    <= ts_next;
        end
    end

    // stage 2: level sum, floored at zero
    logic signed [9:0] lm_sum;
    logic [8:0]        lm_reg;
    logic [6:0]        depth_s2_reg;
    logic signed [6:0] ts_s2_reg;

    assign lm_sum = $signed({2'b00, vprod_reg[13:6]}) + LVL_BASE
                  - $signed({3'b000, sens_reg}) + ks_reg;

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            lm_reg       <= lm_sum[9] ? 9'd0 : lm_sum[8:0];
            depth_s2_reg <= depth_s1_reg;
            ts_s2_reg    <= ts_s1_reg;
        end
    end

    // stage 3: depth scaling and saturation
    logic [15:0]       dprod;
    logic [9:0]        dscaled;
    logic [7:0]        lvl_reg;
    logic signed [6:0] ts_reg;

    assign dprod   = lm_reg * depth_s2_reg;
    assign dscaled = dprod[15:6];

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            lvl_reg <= (|dscaled[9:8]) ? OUT_MAX : dscaled[7:0];
            ts_reg  <= ts_s2_reg;
        end
    end

    assign level_multiplier = lvl_reg;
    assign time_subtraction = ts_reg;

endmodule

`default_nettype wire

FILE: sv/filter_cutoff_and_env_depth_calc_unit.sv
// top level of the note-on filter cutoff and envelope depth unit
`timescale 1ns / 1ps
`default_nettype none

// For each note-on transaction this unit computes the voice filter's base
// cutoff, the filter envelope level multiplier and the key-dependent envelope
// time subtraction from the key, velocity, base pitch and timbre filter
// parameters. It keeps no state between transactions. The datapath is a
// three-stage pipeline: a transaction is loaded into stage 1 at its accepting
// edge, moves through stages 2 and 3, and its result is presented on m_valid
// from the stage 3 registers. A new transaction can be accepted in every cycle
// while m_ready is high, so sustained throughput is then one per cycle.
// The multiplies in each path (key-follow and bias products for the cutoff,
// velocity and depth products for the level) are each followed by a register.
// Each stage has its own valid bit and loads when empty or when its content
// moves on, so bubbles close up under an output stall and s_ready only drops
// when all three stages hold results and m_ready is low. Out-of-range bias
// level indexes read the last table entry, key-follow indexes above 14 read
// the value 21, and depth and time shift selects saturate at four.
module filter_cutoff_and_env_depth_calc_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input transaction channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [6:0]        s_note_key,
    input  wire logic [6:0]        s_note_velocity,
    input  wire logic [15:0]       s_base_pitch,
    input  wire logic [4:0]        s_filter_keyfollow,
    input  wire logic [4:0]        s_pitch_keyfollow,
    input  wire logic [6:0]        s_bias_point,
    input  wire logic [3:0]        s_bias_level,
    input  wire logic [6:0]        s_cutoff_setting,
    input  wire logic [6:0]        s_velo_sensitivity,
    input  wire logic [2:0]        s_depth_keyfollow,
    input  wire logic [6:0]        s_env_depth,
    input  wire logic [2:0]        s_time_keyfollow,
    // result transaction channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_cutoff_out,
    output logic [7:0]             m_level_multiplier,
    output logic signed [6:0]      m_time_subtraction
);
    import fcec_pkg::*;

    fcec_adv_t adv;

    // valid bits and per-stage load strobes
    fcec_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .adv     (adv)
    );

    // key follow, bias, setting offset, pitch limit and final scaling
    fcec_cutoff_path u_cutoff (
        .aclk             (aclk),
        .adv              (adv),
        .note_key         (s_note_key),
        .base_pitch       (s_base_pitch),
        .filter_keyfollow (s_filter_keyfollow),
        .pitch_keyfollow  (s_pitch_keyfollow),
        .bias_point       (s_bias_point),
        .bias_level       (s_bias_level),
        .cutoff_setting   (s_cutoff_setting),
        .cutoff_out       (m_cutoff_out)
    );

    // velocity sensitivity, depth scaling and time key follow
    fcec_level_path u_level (
        .aclk             (aclk),
        .adv              (adv),
        .note_key         (s_note_key),
        .note_velocity    (s_note_velocity),
        .velo_sensitivity (s_velo_sensitivity),
        .depth_keyfollow  (s_depth_keyfollow),
        .env_depth        (s_env_depth),
        .time_keyfollow   (s_time_keyfollow),
        .level_multiplier (m_level_multiplier),
        .time_subtraction (m_time_subtraction)
    );

endmodule

`default_nettype wire

FILE: verif/filter_cutoff_and_env_depth_calc_unit_test.sv
// self-checking testbench for the note-on filter cutoff and envelope depth unit
`timescale 1ns / 1ps

module filter_cutoff_and_env_depth_calc_unit_test;

    // run shape
    localparam int RANDOM_NOTES  = 1950;
    localparam int CALM_NOTES    = 150;     // tail of the run with no idling on either side
    localparam int HOLD_START    = 500;     // receiver holds off around here
    localparam int HOLD_END      = 600;     // sender keeps offering back to back until here
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_AT      = 1200;    // sender waits for every result here
    localparam int SETTLE_CYCLES = 8;       // idle wait after the three-stage pipeline has drained
    localparam int MAX_PRINTED   = 40;
    localparam longint TIMEOUT_NS = 64'd5_000_000;

    // key-follow gain per index, and bias gain per bias level
    localparam int KF_GAIN [17] = '{-21, -10, -5, 0, 2, 5, 8, 10, 13, 16, 18, 21, 26, 32, 42,
                                    21, 21};
    localparam int BIAS_GAIN [15] = '{85, 42, 21, 16, 10, 5, 2, 0, -2, -5, -10, -16, -21, -74,
                                      -85};
    localparam int BIAS_DIR = 6;            // bias point bit that picks above or below

    // one note-on transaction as seen on the input channel
    typedef struct packed {
        logic [6:0]  note_key;
        logic [6:0]  note_velocity;
        logic [15:0] base_pitch;
        logic [4:0]  filter_keyfollow;
        logic [4:0]  pitch_keyfollow;
        logic [6:0]  bias_point;
        logic [3:0]  bias_level;
        logic [6:0]  cutoff_setting;
        logic [6:0]  velo_sensitivity;
        logic [2:0]  depth_keyfollow;
        logic [6:0]  env_depth;
        logic [2:0]  time_keyfollow;
    } note_req_t;

    // the three voice filter settings that come back for it
    typedef struct packed {
        logic [7:0]        cutoff;
        logic [7:0]        level;
        logic signed [6:0] tsub;
    } voice_filter_t;

    // directed row: a note and, where it is obvious, the settings it must give
    typedef struct {
        note_req_t     note;
        bit            known;
        voice_filter_t golden;
    } dir_row_t;

    localparam voice_filter_t NO_GOLDEN = '0;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [6:0]        s_note_key;
    logic [6:0]        s_note_velocity;
    logic [15:0]       s_base_pitch;
    logic [4:0]        s_filter_keyfollow;
    logic [4:0]        s_pitch_keyfollow;
    logic [6:0]        s_bias_point;
    logic [3:0]        s_bias_level;
    logic [6:0]        s_cutoff_setting;
    logic [6:0]        s_velo_sensitivity;
    logic [2:0]        s_depth_keyfollow;
    logic [6:0]        s_env_depth;
    logic [2:0]        s_time_keyfollow;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_cutoff_out;
    logic [7:0]        m_level_multiplier;
    logic signed [6:0] m_time_subtraction;

    // settings still owed by the unit, oldest first
    voice_filter_t voice_filter_due [$];
    int            mismatches = 0;
    bit            calm = 1'b0;         // set for the tail: no gaps, no stalls
    bit            hold_req = 1'b0;     // sender asks the receiver for one long hold-off

    filter_cutoff_and_env_depth_calc_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_note_key         (s_note_key),
        .s_note_velocity    (s_note_velocity),
        .s_base_pitch       (s_base_pitch),
        .s_filter_keyfollow (s_filter_keyfollow),
        .s_pitch_keyfollow  (s_pitch_keyfollow),
        .s_bias_point       (s_bias_point),
        .s_bias_level       (s_bias_level),
        .s_cutoff_setting   (s_cutoff_setting),
        .s_velo_sensitivity (s_velo_sensitivity),
        .s_depth_keyfollow  (s_depth_keyfollow),
        .s_env_depth        (s_env_depth),
        .s_time_keyfollow   (s_time_keyfollow),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_cutoff_out       (m_cutoff_out),
        .m_level_multiplier (m_level_multiplier),
        .m_time_subtraction (m_time_subtraction)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // computes the cutoff, level multiplier and time subtraction of one note
    function automatic voice_filter_t calc_voice_filter(input note_req_t n);
        voice_filter_t r;
        int kd, c, d, over, lm, ts;
        int fi, pi, bi, dsh, tsh;
        // out-of-range indexes and shift selects stick at the last entry
        fi  = (n.filter_keyfollow > 16) ? 16 : int'(n.filter_keyfollow);
        pi  = (n.pitch_keyfollow > 16) ? 16 : int'(n.pitch_keyfollow);
        bi  = (n.bias_level > 14) ? 14 : int'(n.bias_level);
        dsh = (n.depth_keyfollow > 4) ? 4 : int'(n.depth_keyfollow);
        tsh = (n.time_keyfollow > 4) ? 4 : int'(n.time_keyfollow);
        kd  = int'(n.note_key) - 60;

        // base cutoff: key follow difference, then the bias toward one side of the point
        c = (KF_GAIN[fi] - KF_GAIN[pi]) * kd;
        if (n.bias_point[BIAS_DIR] == 1'b0) begin
            d = int'(n.bias_point) + 33 - int'(n.note_key);
            if (d > 0) c = c - d * BIAS_GAIN[bi];
        end else begin
            d = int'(n.bias_point) - 31 - int'(n.note_key);
            if (d < 0) c = c + d * BIAS_GAIN[bi];
        end
        c = c + int'(n.cutoff_setting) * 16 - 800;
        // non-negative values are pulled down so that pitch plus cutoff does not exceed the limit
        if (c >= 0) begin
            over = int'(n.base_pitch >> 4) + c - 3584;
            if (over > 0) c = c - over;
        end else if (c < -2048) begin
            c = -2048;
        end
        c = (c + 2056) >>> 4;
        if (c > 255) c = 255;
        if (c < 0) c = 0;

        // envelope level: velocity scaling, sensitivity offset, key follow, then depth
        lm = (int'(n.note_velocity) * int'(n.velo_sensitivity)) >>> 6;
        lm = lm + 109 - int'(n.velo_sensitivity) + (kd >>> (4 - dsh));
        if (lm < 0) lm = 0;
        lm = (lm * int'(n.env_depth)) >>> 6;
        if (lm > 255) lm = 255;

        // time subtraction, off when the key follow is zero
        ts = (tsh != 0) ? (kd >>> (5 - tsh)) : 0;

        r.cutoff = c[7:0];
        r.level  = lm[7:0];
        r.tsub   = ts[6:0];
        return r;
    endfunction

    function automatic note_req_t mk_note(input int key, input int vel, input int pitch,
                                          input int fkf, input int pkf, input int bpt,
                                          input int blv, input int cut, input int sens,
                                          input int dkf, input int depth, input int tkf);
        note_req_t n;
        n.note_key         = key[6:0];
        n.note_velocity    = vel[6:0];
        n.base_pitch       = pitch[15:0];
        n.filter_keyfollow = fkf[4:0];
        n.pitch_keyfollow  = pkf[4:0];
        n.bias_point       = bpt[6:0];
        n.bias_level       = blv[3:0];
        n.cutoff_setting   = cut[6:0];
        n.velo_sensitivity = sens[6:0];
        n.depth_keyfollow  = dkf[2:0];
        n.env_depth        = depth[6:0];
        n.time_keyfollow   = tkf[2:0];
        return n;
    endfunction

    // mostly a legal value, now and then anything the port width allows
    function automatic int pick_field(input int hi, input int width);
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(0, (1 << width) - 1));
        return int'($urandom_range(0, hi));
    endfunction

    function automatic note_req_t random_note();
        int pitch;
        // low pitches leave room below the limit, high ones make the limit bite
        pitch = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 4095))
                                            : int'($urandom_range(0, 65535));
        return mk_note(pick_field(127, 7), pick_field(127, 7), pitch,
                       pick_field(16, 5), pick_field(16, 5), pick_field(127, 7),
                       pick_field(14, 4), pick_field(100, 7), pick_field(100, 7),
                       pick_field(4, 3), pick_field(100, 7), pick_field(4, 3));
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // offer one note, hold it until accepted, then queue what it must produce
    task automatic offer_note(input note_req_t n, input bit known, input voice_filter_t golden);
        s_valid            <= 1'b1;
        s_note_key         <= n.note_key;
        s_note_velocity    <= n.note_velocity;
        s_base_pitch       <= n.base_pitch;
        s_filter_keyfollow <= n.filter_keyfollow;
        s_pitch_keyfollow  <= n.pitch_keyfollow;
        s_bias_point       <= n.bias_point;
        s_bias_level       <= n.bias_level;
        s_cutoff_setting   <= n.cutoff_setting;
        s_velo_sensitivity <= n.velo_sensitivity;
        s_depth_keyfollow  <= n.depth_keyfollow;
        s_env_depth        <= n.env_depth;
        s_time_keyfollow   <= n.time_keyfollow;
        do @(posedge aclk); while (s_ready !== 1'b1);
        voice_filter_due.push_back(known ? golden : calc_voice_filter(n));
    endtask

    // sender: reset, directed rows, then random notes
    initial begin : drive_notes
        dir_row_t dir_rows [$];
        bit       gappy;
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_note_key         <= '0;
        s_note_velocity    <= '0;
        s_base_pitch       <= '0;
        s_filter_keyfollow <= '0;
        s_pitch_keyfollow  <= '0;
        s_bias_point       <= '0;
        s_bias_level       <= '0;
        s_cutoff_setting   <= '0;
        s_velo_sensitivity <= '0;
        s_depth_keyfollow  <= '0;
        s_env_depth        <= '0;
        s_time_keyfollow   <= '0;

        // all zero: bias pulls the cutoff to the floor, zero depth kills the level
        dir_rows.push_back('{mk_note(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             '{8'd0, 8'd0, 7'sd0}});
        // every field at its port maximum
        dir_rows.push_back('{mk_note(127, 127, 65535, 31, 31, 127, 15, 127, 127, 7, 127, 7),
                             1'b1, '{8'd96, 8'd255, 7'sd33}});
        // cutoff capped at the top
        dir_rows.push_back('{mk_note(127, 0, 0, 14, 0, 0, 0, 100, 0, 0, 0, 0), 1'b1,
                             '{8'd255, 8'd0, 7'sd0}});
        // most negative time subtraction
        dir_rows.push_back('{mk_note(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4), 1'b1,
                             '{8'd0, 8'd0, -7'sd30}});
        // remaining rows go through the predictor
        dir_rows.push_back('{mk_note(60, 64, 16384, 8, 8, 64, 7, 50, 50, 2, 50, 2), 0, NO_GOLDEN});
        dir_rows.push_back('{mk_note(60, 100, 0, 0, 16, 20, 0, 100, 100, 4, 100, 4), 0, NO_GOLDEN});
        dir_rows.push_back('{mk_note(100, 127, 40000, 3, 9, 70, 14, 80, 20, 1, 64, 3), 0,
                             NO_GOLDEN});
        // bias level past the table end
        dir_rows.push_back('{mk_note(20, 90, 1000, 12, 5, 30, 15, 60, 90, 3, 100, 1), 0,
                             NO_GOLDEN});
        // key-follow indexes past the table end
        dir_rows.push_back('{mk_note(90, 10, 50000, 17, 2, 96, 9, 20, 0, 0, 100, 2), 0,
                             NO_GOLDEN});
        dir_rows.push_back('{mk_note(30, 127, 60000, 5, 20, 10, 3, 90, 100, 4, 100, 4), 0,
                             NO_GOLDEN});
        // shift selects past four
        dir_rows.push_back('{mk_note(110, 60, 3000, 9, 1, 80, 11, 100, 60, 5, 80, 5), 0,
                             NO_GOLDEN});
        dir_rows.push_back('{mk_note(5, 30, 20000, 13, 13, 0, 1, 10, 10, 6, 90, 6), 0,
                             NO_GOLDEN});
        // settings above 100
        dir_rows.push_back('{mk_note(64, 127, 10, 10, 4, 64, 6, 127, 127, 3, 127, 3), 0,
                             NO_GOLDEN});
        dir_rows.push_back('{mk_note(127, 50, 8000, 16, 0, 127, 13, 110, 101, 1, 101, 1), 0,
                             NO_GOLDEN});
        dir_rows.push_back('{mk_note(0, 127, 65535, 0, 14, 63, 2, 0, 127, 2, 127, 3), 0,
                             NO_GOLDEN});
        // bias point either side of the direction bit
        dir_rows.push_back('{mk_note(70, 1, 5000, 7, 7, 64, 0, 50, 1, 0, 30, 2), 0, NO_GOLDEN});
        dir_rows.push_back('{mk_note(40, 2, 7000, 6, 11, 63, 12, 40, 5, 4, 60, 4), 0, NO_GOLDEN});
        // pitch limit and cutoff floor
        dir_rows.push_back('{mk_note(100, 80, 65535, 14, 0, 0, 0, 100, 40, 4, 100, 4), 0,
                             NO_GOLDEN});
        dir_rows.push_back('{mk_note(0, 40, 0, 0, 14, 0, 0, 0, 30, 0, 20, 1), 0, NO_GOLDEN});
        // level goes negative before the depth multiply
        dir_rows.push_back('{mk_note(0, 0, 1234, 4, 4, 40, 5, 30, 127, 4, 127, 2), 0, NO_GOLDEN});
        // keys just around the center
        dir_rows.push_back('{mk_note(59, 64, 30000, 11, 3, 100, 8, 70, 70, 3, 70, 3), 0,
                             NO_GOLDEN});
        dir_rows.push_back('{mk_note(61, 64, 30000, 3, 11, 100, 8, 70, 70, 3, 70, 3), 0,
                             NO_GOLDEN});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            offer_note(dir_rows[i].note, dir_rows[i].known, dir_rows[i].golden);

        gappy = 1'b1;
        for (int i = 0; i < RANDOM_NOTES; i++) begin
            if (i == RANDOM_NOTES - CALM_NOTES)
                calm = 1'b1;
            // alternate stretches with and without gaps
            if (i % 64 == 0)
                gappy = ($urandom_range(0, 2) != 0);
            // long receiver hold-off while notes keep coming back to back
            if (i == HOLD_START)
                hold_req = 1'b1;
            // let the pipeline run dry once
            if (i == DRAIN_AT) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (voice_filter_due.size() != 0);
            end
            if (!calm && gappy && (i < HOLD_START || i > HOLD_END)
                    && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            offer_note(random_note(), 1'b0, NO_GOLDEN);
        end
        s_valid <= 1'b0;

        // wait for the tail, then wait out SETTLE_CYCLES to catch any stray result
        while (voice_filter_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // receiver: random ready bursts, one long hold-off, steady at the end
    initial begin : drive_ready
        bit lvl;
        int len;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (hold_req) begin
                // the pipeline fills and s_ready must drop while this lasts
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                lvl = ($urandom_range(0, 3) != 0);
                len = int'($urandom_range(1, 16));
                // now and then a long stall-free stretch
                if (lvl && $urandom_range(0, 7) == 0)
                    len = 64;
                m_ready <= lvl;
                repeat (len) @(posedge aclk);
            end
        end
    end

    // compare each accepted result transaction with the oldest owed settings
    always @(posedge aclk) begin : check_results
        voice_filter_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (voice_filter_due.size() == 0) begin
                report_mismatch("result transaction with nothing outstanding");
            end else begin
                want = voice_filter_due.pop_front();
                if (m_cutoff_out !== want.cutoff)
                    report_mismatch($sformatf("cutoff_out got %0d want %0d",
                                              m_cutoff_out, want.cutoff));
                if (m_level_multiplier !== want.level)
                    report_mismatch($sformatf("level_multiplier got %0d want %0d",
                                              m_level_multiplier, want.level));
                if (m_time_subtraction !== want.tsub)
                    report_mismatch($sformatf("time_subtraction got %0d want %0d",
                                              m_time_subtraction, want.tsub));
            end
        end
    end

    // hard stop if the run hangs
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
